// ===== hdl/stp_pkg.sv =====
// ----------------------------------------------------------------------------
// stp_pkg
// Shared widths, defaults and control types of the stride prefetch table.
// ----------------------------------------------------------------------------
package stp_pkg;

  localparam int KEY_W    = 32;
  localparam int ADDR_W   = 48;
  localparam int TIME_W   = 32;
  localparam int BLOCK_W  = 43;
  localparam int STRIDE_W = 44;

  localparam int DEF_ENTRIES     = 16;
  localparam int DEF_BLOCK_BYTES = 32;

  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [BLOCK_W-1:0]  last_block;
    logic [STRIDE_W-1:0] stride;
    logic [TIME_W-1:0]   last_time;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic update;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;
    logic div_ready;
  } stat_t;

endpackage

// ===== hdl/stp_blkdiv.sv =====
// ----------------------------------------------------------------------------
// stp_blkdiv
// Byte address to block address. A shift when the block size is a power of
// two, otherwise a multiply by the rounded-up reciprocal of the block size,
// done serially in five 10-bit slices.
// ----------------------------------------------------------------------------
module stp_blkdiv #(
  parameter int BLOCK_BYTES = stp_pkg::DEF_BLOCK_BYTES
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [stp_pkg::ADDR_W-1:0]  dividend,
  output logic                        ready,
  output logic [stp_pkg::BLOCK_W-1:0] block
);

  localparam bit IS_POW2 = ((BLOCK_BYTES & (BLOCK_BYTES - 1)) == 0);

  generate
    if (IS_POW2) begin : g_shift
      localparam int SHIFT = $clog2(BLOCK_BYTES);
      logic [stp_pkg::ADDR_W-1:0] quo;

      always_ff @(posedge clk) begin
        if (rst) begin
          ready <= 1'b0;
        end else if (start) begin
          ready <= 1'b1;
        end
      end

      always_ff @(posedge clk) begin
        if (start) begin
          quo <= dividend >> SHIFT;
        end
      end

      assign block = quo[stp_pkg::BLOCK_W-1:0];
    end else begin : g_recip
      localparam int NCHUNK  = 5;
      localparam int CHUNK_W = 10;
      localparam int RCP_W   = NCHUNK * CHUNK_W;
      localparam int SUM_W   = stp_pkg::ADDR_W + CHUNK_W;
      localparam int LOG_B   = $clog2(BLOCK_BYTES);
      localparam int SH      = stp_pkg::ADDR_W + LOG_B;
      localparam int FSH     = SH - RCP_W;
      localparam int CNT_W   = $clog2(NCHUNK);
      // ceil(2^SH / BLOCK_BYTES) is exact for every 48-bit dividend
      localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SH) + 64'(BLOCK_BYTES - 1)) / 64'(BLOCK_BYTES);
      localparam logic [RCP_W-1:0] RECIP     = RECIP_FULL[RCP_W-1:0];
      localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(NCHUNK - 1);

      logic                       running;
      logic [CNT_W-1:0]           step;
      logic [stp_pkg::ADDR_W-1:0] x;
      logic [RCP_W-1:0]           mult;
      logic [stp_pkg::ADDR_W-1:0] acc;
      logic [SUM_W-1:0]           prod;
      logic [SUM_W-1:0]           sum;
      logic [stp_pkg::ADDR_W-1:0] quo;

      // low slice first; the 10 low bits of each partial sum are retired
      assign prod = {{CHUNK_W{1'b0}}, x} * {{stp_pkg::ADDR_W{1'b0}}, mult[CHUNK_W-1:0]};
      assign sum  = {{CHUNK_W{1'b0}}, acc} + prod;

      always_ff @(posedge clk) begin
        if (rst) begin
          running <= 1'b0;
          ready   <= 1'b0;
          step    <= '0;
        end else if (start) begin
          running <= 1'b1;
          ready   <= 1'b0;
          step    <= '0;
        end else if (running) begin
          step <= step + 1'b1;
          if (step == LAST_STEP) begin
            running <= 1'b0;
            ready   <= 1'b1;
          end
        end
      end

      always_ff @(posedge clk) begin
        if (start) begin
          x    <= dividend;
          mult <= RECIP;
          acc  <= '0;
        end else if (running) begin
          acc  <= sum[SUM_W-1:CHUNK_W];
          mult <= {{CHUNK_W{1'b0}}, mult[RCP_W-1:CHUNK_W]};
        end
      end

      assign quo   = acc >> FSH;
      assign block = quo[stp_pkg::BLOCK_W-1:0];
    end
  endgenerate

endmodule

// ===== hdl/stp_dpath.sv =====
// ----------------------------------------------------------------------------
// stp_dpath
// Entry table, entry scan (key match, first free slot, oldest entry) and the
// stride update / prefetch decision.
// ----------------------------------------------------------------------------
module stp_dpath #(
  parameter int ENTRIES = stp_pkg::DEF_ENTRIES
) (
  input  logic                        clk,
  input  logic                        rst,
  input  stp_pkg::cmd_t               cmd,
  input  logic [stp_pkg::KEY_W-1:0]   access_key,
  input  logic [stp_pkg::TIME_W-1:0]  access_time,
  input  logic [stp_pkg::BLOCK_W-1:0] block,
  output logic                        scan_done,
  output logic                        prefetch_valid,
  output logic [stp_pkg::BLOCK_W-1:0] prefetch_block
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [CW-1:0] LAST_CNT = CW'(ENTRIES);

  stp_pkg::entry_t mem [ENTRIES];
  logic [ENTRIES-1:0] valid;

  logic [stp_pkg::KEY_W-1:0]  key_q;
  logic [stp_pkg::TIME_W-1:0] time_q;

  logic [CW-1:0]   cnt;
  logic            rd_pend;
  logic [IW-1:0]   rd_idx;
  stp_pkg::entry_t rd_ent;

  logic                         hit;
  logic [IW-1:0]                hit_idx;
  logic [stp_pkg::BLOCK_W-1:0]  hit_last;
  logic [stp_pkg::STRIDE_W-1:0] hit_stride;
  logic                         inv_any;
  logic [IW-1:0]                inv_idx;
  logic                         lru_any;
  logic [IW-1:0]                lru_idx;
  logic [stp_pkg::TIME_W-1:0]   lru_time;

  logic                         rd_vld;
  logic                         rd_match;
  logic                         same_blk;
  logic                         stride_zero;
  logic                         stride_hit;
  logic                         pf;
  logic [stp_pkg::BLOCK_W-1:0]  pred_blk;
  logic [stp_pkg::STRIDE_W-1:0] new_stride;
  logic [IW-1:0]                wr_idx;
  stp_pkg::entry_t              wr_ent;

  // ---- table storage ----
  always_ff @(posedge clk) begin
    if (cmd.scan && (cnt != LAST_CNT)) begin
      rd_ent <= mem[cnt[IW-1:0]];
    end
    if (cmd.update) begin
      mem[wr_idx] <= wr_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (cmd.update) begin
      valid[wr_idx] <= 1'b1;
    end
  end

  // ---- scan ----
  assign rd_vld    = valid[rd_idx];
  assign rd_match  = rd_vld && (rd_ent.key == key_q);
  assign scan_done = (cnt == LAST_CNT) && !rd_pend;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_q  <= access_key;
      time_q <= access_time;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      rd_pend <= 1'b0;
      hit     <= 1'b0;
      inv_any <= 1'b0;
      lru_any <= 1'b0;
    end else if (cmd.load) begin
      cnt     <= '0;
      rd_pend <= 1'b0;
      hit     <= 1'b0;
      inv_any <= 1'b0;
      lru_any <= 1'b0;
    end else if (cmd.scan) begin
      if (cnt != LAST_CNT) begin
        cnt     <= cnt + 1'b1;
        rd_pend <= 1'b1;
      end else begin
        rd_pend <= 1'b0;
      end
      if (rd_pend) begin
        if (rd_match) begin
          hit <= 1'b1;
        end
        if (!rd_vld) begin
          inv_any <= 1'b1;
        end else begin
          lru_any <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      if (cnt != LAST_CNT) begin
        rd_idx <= cnt[IW-1:0];
      end
      if (rd_pend) begin
        // first matching entry only
        if (rd_match && !hit) begin
          hit_idx    <= rd_idx;
          hit_last   <= rd_ent.last_block;
          hit_stride <= rd_ent.stride;
        end
        if (!rd_vld && !inv_any) begin
          inv_idx <= rd_idx;
        end
        // strict less keeps the lowest index on equal times
        if (rd_vld && (!lru_any || (rd_ent.last_time < lru_time))) begin
          lru_idx  <= rd_idx;
          lru_time <= rd_ent.last_time;
        end
      end
    end
  end

  // ---- update ----
  assign same_blk    = (hit_last == block);
  assign stride_zero = (hit_stride == '0);
  assign pred_blk    = hit_last + hit_stride[stp_pkg::BLOCK_W-1:0];
  assign stride_hit  = (pred_blk == block);
  assign new_stride  = {1'b0, block} - {1'b0, hit_last};
  assign pf          = hit && !same_blk && !stride_zero && stride_hit;

  always_comb begin
    wr_ent.key        = key_q;
    wr_ent.last_block = block;
    wr_ent.last_time  = time_q;
    if (!hit) begin
      wr_ent.stride = '0;
    end else if (same_blk || (!stride_zero && stride_hit)) begin
      wr_ent.stride = hit_stride;
    end else begin
      wr_ent.stride = new_stride;
    end
    if (hit) begin
      wr_idx = hit_idx;
    end else if (inv_any) begin
      wr_idx = inv_idx;
    end else begin
      wr_idx = lru_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      prefetch_valid <= pf;
      prefetch_block <= pf ? (block + hit_stride[stp_pkg::BLOCK_W-1:0]) : '0;
    end
  end

endmodule

// ===== hdl/stp_ctrl.sv =====
// ----------------------------------------------------------------------------
// stp_ctrl
// Sequencer: accept, scan and divide, update, then strobe the result.
// ----------------------------------------------------------------------------
module stp_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  stp_pkg::stat_t stat,
  output stp_pkg::cmd_t  cmd,
  output logic           busy,
  output logic           done
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WORK = 3'b010,
    S_UPD  = 3'b100
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_WORK;
        end
      end
      S_WORK: begin
        if (stat.scan_done && stat.div_ready) begin
          state_next = S_UPD;
        end
      end
      S_UPD: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_UPD);
    end
  end

  assign busy       = (state != S_IDLE);
  assign cmd.load   = start && (state == S_IDLE);
  assign cmd.scan   = (state == S_WORK);
  assign cmd.update = (state == S_UPD);

endmodule

// ===== hdl/stride_prefetch_table.sv =====
// ----------------------------------------------------------------------------
// stride_prefetch_table
// Reference prediction table of a stride prefetcher.
// ----------------------------------------------------------------------------
// An access is taken when start is high and busy is low; its result appears
// on prefetch_valid / prefetch_block with done high for exactly one cycle,
// cannot be held off, and stays on those outputs until the next access is
// updated. The table is scanned one entry per cycle through a single memory
// read port. When BLOCK_BYTES is not a power of two the block address comes
// from a reciprocal multiply that runs alongside the scan.
module stride_prefetch_table #(
  parameter int ENTRIES     = stp_pkg::DEF_ENTRIES,
  parameter int BLOCK_BYTES = stp_pkg::DEF_BLOCK_BYTES
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [stp_pkg::KEY_W-1:0]   access_key,
  input  logic [stp_pkg::ADDR_W-1:0]  byte_address,
  input  logic [stp_pkg::TIME_W-1:0]  access_time,
  output logic                        done,
  output logic                        prefetch_valid,
  output logic [stp_pkg::BLOCK_W-1:0] prefetch_block
);

  stp_pkg::cmd_t               cmd;
  stp_pkg::stat_t              stat;
  logic [stp_pkg::BLOCK_W-1:0] block;
  logic                        div_ready;
  logic                        scan_done;

  assign stat.scan_done = scan_done;
  assign stat.div_ready = div_ready;

  stp_blkdiv #(
    .BLOCK_BYTES(BLOCK_BYTES)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.load),
    .dividend(byte_address),
    .ready   (div_ready),
    .block   (block)
  );

  stp_dpath #(
    .ENTRIES(ENTRIES)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .access_key    (access_key),
    .access_time   (access_time),
    .block         (block),
    .scan_done     (scan_done),
    .prefetch_valid(prefetch_valid),
    .prefetch_block(prefetch_block)
  );

  stp_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .stat (stat),
    .cmd  (cmd),
    .busy (busy),
    .done (done)
  );

  // ---- checks ----
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after an accepted transfer");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) && !busy))
    else $error("result strobe outside the end of an access");

  a_no_pf_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !prefetch_valid) |-> (prefetch_block == '0))
    else $error("prefetch block nonzero without a prefetch");

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the stride prefetch table: a queue-fed driver
// issues accesses, a shadow table predicts each result, and a monitor
// compares every done strobe against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int KEY_W       = stp_pkg::KEY_W;
  localparam int ADDR_W      = stp_pkg::ADDR_W;
  localparam int TIME_W      = stp_pkg::TIME_W;
  localparam int BLOCK_W     = stp_pkg::BLOCK_W;
  localparam int NUM_ENT     = stp_pkg::DEF_ENTRIES;
  localparam int BLK_BYTES   = stp_pkg::DEF_BLOCK_BYTES;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int TAIL_CYCLES = 2 * (NUM_ENT + 53);
  localparam int N_STREAMS   = 24;
  localparam int PHASE_ITEMS = 456;

  typedef struct {
    logic [KEY_W-1:0]  key;
    logic [ADDR_W-1:0] addr;
    logic [TIME_W-1:0] tstamp;
    int                idle_pct;
    bit                drain;
  } access_req_t;

  typedef struct packed {
    logic               valid;
    logic [BLOCK_W-1:0] block;
  } pf_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic [KEY_W-1:0]   access_key = '0;
  logic [ADDR_W-1:0]  byte_address = '0;
  logic [TIME_W-1:0]  access_time = '0;
  logic               busy;
  logic               done;
  logic               prefetch_valid;
  logic [BLOCK_W-1:0] prefetch_block;

  access_req_t access_q[$];
  pf_result_t  pf_expected_q[$];

  // shadow copy of the prediction table
  stp_pkg::entry_t tbl[NUM_ENT];
  logic            tbl_valid[NUM_ENT];

  int n_accepted = 0;
  int n_prefetch = 0;
  int n_relearn  = 0;
  int n_evict    = 0;
  int n_mismatch = 0;
  int n_drain    = 0;
  int n_cycles   = 0;
  bit taken      = 1'b0;

  stride_prefetch_table uut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .access_key    (access_key),
    .byte_address  (byte_address),
    .access_time   (access_time),
    .done          (done),
    .prefetch_valid(prefetch_valid),
    .prefetch_block(prefetch_block)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Look up one access in the shadow table, update it, return the prefetch.
  function automatic pf_result_t rpt_access(input logic [KEY_W-1:0] key,
                                            input logic [ADDR_W-1:0] addr,
                                            input logic [TIME_W-1:0] now);
    logic [63:0]        quo;
    logic [BLOCK_W-1:0] blk;
    logic [BLOCK_W-1:0] next_blk;
    pf_result_t         res;
    int                 hit;
    int                 victim;
    quo = {16'd0, addr} / 64'(BLK_BYTES);
    blk = quo[BLOCK_W-1:0];
    res = '0;
    hit = -1;
    for (int i = 0; i < NUM_ENT; i++) begin
      if (hit < 0 && tbl_valid[i] && tbl[i].key == key) hit = i;
    end
    if (hit >= 0) begin
      next_blk = tbl[hit].last_block + tbl[hit].stride[BLOCK_W-1:0];
      if (tbl[hit].last_block == blk) begin
        // same block: time refresh only
      end else if (tbl[hit].stride == '0) begin
        tbl[hit].stride = {1'b0, blk} - {1'b0, tbl[hit].last_block};
      end else if (next_blk == blk) begin
        res.valid = 1'b1;
        res.block = blk + tbl[hit].stride[BLOCK_W-1:0];
        n_prefetch++;
      end else begin
        tbl[hit].stride = {1'b0, blk} - {1'b0, tbl[hit].last_block};
        n_relearn++;
      end
      tbl[hit].last_block = blk;
      tbl[hit].last_time  = now;
    end else begin
      victim = -1;
      for (int i = 0; i < NUM_ENT; i++) begin
        if (victim < 0 && !tbl_valid[i]) victim = i;
      end
      if (victim < 0) begin
        // LRU, lowest index on equal times
        victim = 0;
        for (int i = 1; i < NUM_ENT; i++) begin
          if (tbl[i].last_time < tbl[victim].last_time) victim = i;
        end
        n_evict++;
      end
      tbl_valid[victim]       = 1'b1;
      tbl[victim].key         = key;
      tbl[victim].last_block  = blk;
      tbl[victim].stride      = '0;
      tbl[victim].last_time   = now;
    end
    return res;
  endfunction

  task automatic queue_access(input logic [KEY_W-1:0] key, input logic [ADDR_W-1:0] addr,
                              input logic [TIME_W-1:0] tstamp, input int idle_pct,
                              input bit drain);
    access_req_t req;
    req = '{key, addr, tstamp, idle_pct, drain};
    access_q.push_back(req);
  endtask

  task automatic report_mismatch(input string what, input pf_result_t exp_r,
                                 input pf_result_t act_r);
    n_mismatch++;
    if (n_mismatch <= 10)
      $display("mismatch (%s): expected valid=%0b block=%h, got valid=%0b block=%h",
               what, exp_r.valid, exp_r.block, act_r.valid, act_r.block);
  endtask

  // Driver: presents the next access once the previous transfer is taken.
  always @(negedge clk) begin : drv
    access_req_t req;
    logic        go;
    go = 1'b0;
    if (rst) begin
      start <= 1'b0;
    end else if (!start || taken) begin
      if (access_q.size() != 0 && !(access_q[0].drain && pf_expected_q.size() != 0) &&
          $urandom_range(0, 99) >= access_q[0].idle_pct) begin
        req = access_q.pop_front();
        if (req.drain) n_drain++;
        access_key   <= req.key;
        byte_address <= req.addr;
        access_time  <= req.tstamp;
        go = 1'b1;
      end
      start <= go;
    end
  end

  // Monitor: predicts on each accepted transfer, checks each done strobe.
  always @(posedge clk) begin : mon
    pf_result_t exp_r;
    pf_result_t act_r;
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               n_cycles, pf_expected_q.size());
      $display("== FAIL ==");
      $finish;
    end else begin
      taken = !rst && start && !busy;
      if (rst) begin
        for (int i = 0; i < NUM_ENT; i++) begin
          tbl[i]       = '0;
          tbl_valid[i] = 1'b0;
        end
      end else begin
        act_r.valid = prefetch_valid;
        act_r.block = prefetch_block;
        if (done) begin
          if (pf_expected_q.size() == 0) begin
            report_mismatch("result with none outstanding", '0, act_r);
          end else begin
            exp_r = pf_expected_q.pop_front();
            if (act_r.valid !== exp_r.valid || act_r.block !== exp_r.block)
              report_mismatch("prefetch", exp_r, act_r);
          end
        end
        if (taken) begin
          pf_expected_q.push_back(rpt_access(access_key, byte_address, access_time));
          n_accepted++;
        end
      end
    end
  end

  initial begin
    logic [KEY_W-1:0]   s_key[N_STREAMS];
    logic [BLOCK_W-1:0] s_blk[N_STREAMS];
    logic [BLOCK_W-1:0] s_stride[N_STREAMS];
    logic [TIME_W-1:0]  tnow;
    logic [TIME_W-1:0]  t;
    logic [KEY_W-1:0]   k;
    logic [ADDR_W-1:0]  a;
    int                 j;
    int                 r;
    int                 m;
    int                 idle;

    // key 0 against reset entries, same block, learn, two hits, relearn
    queue_access(32'h0, 48'h0, 32'h0, 0, 0);
    queue_access(32'h0, 48'h1F, 32'h1, 0, 0);
    queue_access(32'h0, 48'h40, 32'h2, 0, 0);
    queue_access(32'h0, 48'h80, 32'h3, 0, 0);
    queue_access(32'h0, 48'hC0, 32'h4, 0, 0);
    queue_access(32'h0, 48'h200, 32'h5, 0, 0);
    // top of the address space, negative stride
    queue_access(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 0, 0);
    queue_access(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFC0, 32'h7, 0, 0);
    queue_access(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFA0, 32'h8, 0, 0);
    // positive stride wrapping through block zero
    queue_access(32'hA5A5_A5A5, 48'hFFFF_FFFF_FF80, 32'h9, 0, 0);
    queue_access(32'hA5A5_A5A5, 48'hFFFF_FFFF_FFC0, 32'hA, 0, 0);
    queue_access(32'hA5A5_A5A5, 48'h1F, 32'hB, 0, 0);
    // fill the table with equal times, then force two LRU evictions
    for (int i = 0; i < NUM_ENT - 3; i++)
      queue_access(32'h0100_0000 + i, ADDR_W'({$urandom, $urandom}), 32'h3, 0, 0);
    queue_access(32'h8000_0001, 48'h5555_5555_5555, 32'hC, 0, 0);
    queue_access(32'h7FFF_FFFE, 48'hAAAA_AAAA_AAAA, 32'hC, 0, 0);

    // random part: mostly strided streams, some noise and broken strides
    tnow = $urandom;
    for (int s = 0; s < N_STREAMS; s++) begin
      s_key[s] = $urandom;
      s_blk[s] = BLOCK_W'({$urandom, $urandom});
      s_stride[s] = BLOCK_W'($urandom_range(1, 6));
      if ($urandom_range(0, 1) == 1) s_stride[s] = -s_stride[s];
      if ($urandom_range(0, 7) == 0) s_stride[s] = BLOCK_W'({$urandom, $urandom});
    end
    for (int p = 0; p < 4; p++) begin
      idle = (p == 1) ? 76 : (p == 3) ? 36 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(0, 99);
        tnow = tnow + $urandom_range(0, 2);
        t = ($urandom_range(0, 49) == 0) ? TIME_W'($urandom) : tnow;
        if (r < 12) begin
          k = (r < 6) ? KEY_W'($urandom) : s_key[$urandom_range(0, N_STREAMS - 1)];
          a = ADDR_W'({$urandom, $urandom});
        end else begin
          // a working set that mostly fits the table
          j = ($urandom_range(0, 9) == 0) ? $urandom_range(12, N_STREAMS - 1)
                                          : $urandom_range(0, 11);
          m = $urandom_range(0, 19);
          if (m == 0) begin
            s_stride[j] = BLOCK_W'($urandom_range(1, 9));
            if ($urandom_range(0, 1) == 1) s_stride[j] = -s_stride[j];
          end
          if (m != 1) s_blk[j] = s_blk[j] + s_stride[j];
          k = s_key[j];
          a = ADDR_W'(64'(s_blk[j]) * 64'(BLK_BYTES) + 64'($urandom_range(0, BLK_BYTES - 1)));
        end
        queue_access(k, a, t, idle, n == 0);
      end
    end

    repeat (5) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (access_q.size() != 0 || start || pf_expected_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (pf_expected_q.size() != 0) begin
      $display("%0d results never arrived", pf_expected_q.size());
      n_mismatch += pf_expected_q.size();
    end
    $display("covered %0d accesses in %0d cycles, %0d drain pauses",
             n_accepted, n_cycles, n_drain);
    $display("stride hits %0d, relearns %0d, live-entry evictions %0d, mismatches %0d",
             n_prefetch, n_relearn, n_evict, n_mismatch);
    if (n_mismatch == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== stride_prefetch_table.f =====
hdl/stp_pkg.sv
hdl/stp_blkdiv.sv
hdl/stp_dpath.sv
hdl/stp_ctrl.sv
hdl/stride_prefetch_table.sv
dv/tb_top.sv
